// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

  // Alphabet offsets for the standard base64 table.
  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] PLUS_VAL   = 6'd62;
  localparam logic [5:0] SLASH_VAL  = 6'd63;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_OK      = 2'd1,
    KIND_BADCHAR = 2'd2,
    KIND_BADLEN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       char_present;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      result_kind;
    logic       last_result;
  } out_item_t;

  // Work handed from the front part to the back part for one input item.
  typedef struct packed {
    logic [23:0] triple;    // decoded group, first byte in the top bits
    logic [1:0]  nbytes;    // data bytes to emit (0..3)
    logic        has_end;   // a status result follows the data bytes
    kind_t       end_kind;  // status of the closed stream
  } job_t;

endpackage

// ===== rtl/b64d_front.sv =====
module b64d_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  b64d_pkg::in_item_t in_data,
  input  logic               queue_full,
  output logic               push,
  output b64d_pkg::job_t     job
);
  import b64d_pkg::*;

  typedef struct packed {
    logic [5:0] val;
    logic       pad;
    logic       bad;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = '{val: 6'd0, pad: 1'b0, bad: 1'b0};
    if (c inside {[8'h41:8'h5A]}) begin
      r.val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.val = 6'(c - 8'h61) + LOWER_BASE;
    end else if (c inside {[8'h30:8'h39]}) begin
      r.val = 6'(c - 8'h30) + DIGIT_BASE;
    end else if (c == 8'h2B) begin
      r.val = PLUS_VAL;
    end else if (c == 8'h2F) begin
      r.val = SLASH_VAL;
    end else if (c == PAD_CHAR) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic        bad_r, bad_nxt;

  char_class_t cls;
  logic        in_fire;
  logic        is_space;
  logic        kept;
  logic [2:0]  pad_sum;
  logic        bad_sum;

  assign in_ready = !queue_full;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cls      = classify(in_data.in_char);
    is_space = (in_data.in_char == 8'h20) || (in_data.in_char inside {[8'h09:8'h0D]});
    kept     = in_data.char_present && !is_space;
    pad_sum  = pad_r + {2'b00, cls.pad};
    bad_sum  = bad_r || cls.bad;

    acc_nxt = acc_r;
    pos_nxt = pos_r;
    pad_nxt = pad_r;
    bad_nxt = bad_r;
    job     = '{triple: 24'd0, nbytes: 2'd0, has_end: 1'b0, end_kind: KIND_OK};

    if (kept) begin
      bad_nxt = bad_sum;
      if (pos_r == 2'd3) begin
        job.triple = {acc_r, cls.val};
        if (bad_sum) begin
          job.nbytes = 2'd0;
        end else if (pad_sum == 3'd0) begin
          job.nbytes = 2'd3;
        end else if (pad_sum == 3'd1) begin
          job.nbytes = 2'd2;
        end else begin
          job.nbytes = 2'd1;
        end
        acc_nxt = 18'd0;
        pos_nxt = 2'd0;
        pad_nxt = 3'd0;
      end else begin
        acc_nxt = {acc_r[11:0], cls.val};
        pos_nxt = pos_r + 2'd1;
        pad_nxt = pad_sum;
      end
    end

    if (in_data.end_of_text) begin
      job.has_end = 1'b1;
      if (pos_nxt != 2'd0) begin
        job.end_kind = KIND_BADLEN;
      end else if (bad_nxt) begin
        job.end_kind = KIND_BADCHAR;
      end else begin
        job.end_kind = KIND_OK;
      end
      acc_nxt = 18'd0;
      pos_nxt = 2'd0;
      pad_nxt = 3'd0;
      bad_nxt = 1'b0;
    end

    push = in_fire && ((job.nbytes != 2'd0) || job.has_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 18'd0;
      pos_r <= 2'd0;
      pad_r <= 3'd0;
      bad_r <= 1'b0;
    end else if (in_fire) begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
      pad_r <= pad_nxt;
      bad_r <= bad_nxt;
    end
  end

  // An end item always leaves a fresh stream behind.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.end_of_text |=> pos_r == 2'd0 && !bad_r && pad_r == 3'd0)
    else $error("stream state not cleared after end of text");

endmodule

// ===== rtl/b64d_queue.sv =====
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::job_t push_data,
  input  logic           pop,
  output b64d_pkg::job_t pop_data,
  output logic           not_empty,
  output logic           full
);
  import b64d_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("job queue read while empty");

endmodule

// ===== rtl/b64d_back.sv =====
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  b64d_pkg::job_t      job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_item_t out_data
);
  import b64d_pkg::*;

  job_t      work_r, work_nxt;
  logic      work_valid_r, work_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic      advance;
  logic      emit;
  logic      final_res;
  out_item_t res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    advance = !out_valid_r || out_ready;
    emit    = work_valid_r && advance;

    if (work_r.has_end) begin
      final_res = (idx_r == work_r.nbytes);
    end else begin
      final_res = ({1'b0, idx_r} + 3'd1 == {1'b0, work_r.nbytes});
    end

    res.last_result = final_res;
    if (idx_r < work_r.nbytes) begin
      res.result_kind = KIND_DATA;
      case (idx_r)
        2'd0:    res.out_byte = work_r.triple[23:16] & BYTE_MASK;
        2'd1:    res.out_byte = work_r.triple[15:8] & BYTE_MASK;
        default: res.out_byte = work_r.triple[7:0] & BYTE_MASK;
      endcase
    end else begin
      res.result_kind = work_r.end_kind;
      res.out_byte    = 8'd0;
    end

    pop = job_valid && (!work_valid_r || (emit && final_res));

    work_nxt       = work_r;
    work_valid_nxt = work_valid_r;
    idx_nxt        = idx_r;
    if (pop) begin
      work_nxt       = job;
      work_valid_nxt = 1'b1;
      idx_nxt        = 2'd0;
    end else if (emit && final_res) begin
      work_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      idx_r        <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    out_data_r <= out_data_nxt;
  end

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind != KIND_DATA |-> out_data_r.last_result)
    else $error("status result not marked last");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind != KIND_DATA |-> out_data_r.out_byte == 8'd0)
    else $error("status result carries a nonzero byte");

endmodule

// ===== rtl/base64_stream_decoder_unit.sv =====
// Streaming base64 decoder. Each input transfer carries at most one text character
// (char_present) and may close the text (end_of_text). Whitespace is skipped, the
// standard alphabet decodes to six bits per character, and '=' decodes as zero while
// counting as padding. Every fourth kept character yields one to three data bytes
// (result_kind 0), one result transfer each; an end marker yields one status result
// (1 ok, 2 invalid character, 3 incomplete group), and last_result flags the final
// result of each input item. After an invalid character no further bytes come out,
// and on any error status the consumer should drop the bytes of that text.
// Rate: one input transfer per clock, and one result transfer per clock while out_ready
// is high. The result port is what bounds the sustained rate: a group of four characters
// produces up to three bytes, so plain text streams at one character per cycle, while an
// item that produces several results holds the back end until all of them are sent. A
// queue of QUEUE_DEPTH decoded jobs between the character front end and the result back
// end absorbs such bursts and stalls; in_ready drops only when that queue is full. An
// item's first result passes through the queue, work_r and the output register.
module base64_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_item_t out_data
);
  import b64d_pkg::*;

  // Front to queue.
  logic push;
  job_t push_job;
  logic queue_full;

  // Queue to back.
  logic job_valid;
  job_t pop_job;
  logic pop;

  // The front end classifies each character, tracks the group and pad state, and
  // turns every item that causes results into one job.
  b64d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  // Short job queue so the two sides stall independently.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .not_empty (job_valid),
    .full      (queue_full)
  );

  // The back end walks each job, one result per transfer, into an output register.
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/base64_stream_decoder_unit_test.sv =====
module base64_stream_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  // Scoreboard for the decoder. It keeps its own copy of the decoding state,
  // turns every accepted input transfer into the result transfers that the
  // block owes for it, and checks each result transfer against the oldest one
  // still owed.
  class b64_scoreboard;
    logic [17:0] acc;
    logic [1:0]  pos;
    logic [2:0]  pads;
    logic        bad_seen;
    out_item_t   owed[$];
    int          errors;
    int          checked;
    int          texts_closed;

    function void clear_group();
      acc  = '0;
      pos  = '0;
      pads = '0;
    endfunction

    // Starts from the same fresh stream state as the block after reset.
    function new();
      clear_group();
      bad_seen = 1'b0;
    endfunction

    function bit is_space(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function void push_byte(ref out_item_t burst[$], input logic [7:0] b);
      out_item_t r;
      r.out_byte    = b;
      r.result_kind = KIND_DATA;
      r.last_result = 1'b0;
      burst.push_back(r);
    endfunction

    function void note_transfer(in_item_t it);
      logic [5:0]  v;
      logic [23:0] triple;
      logic [7:0]  c;
      out_item_t   r;
      out_item_t   burst[$];
      c = it.in_char;
      v = '0;
      if (it.char_present && !is_space(c)) begin
        if (c >= 8'h41 && c <= 8'h5A) v = 6'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) v = 6'(c - 8'h61) + LOWER_BASE;
        else if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30) + DIGIT_BASE;
        else if (c == 8'h2B) v = PLUS_VAL;
        else if (c == 8'h2F) v = SLASH_VAL;
        else if (c == PAD_CHAR) pads = pads + 3'd1;
        else bad_seen = 1'b1;
        if (pos == 2'd3) begin
          triple = {acc, v};
          if (!bad_seen) begin
            push_byte(burst, triple[23:16]);
            if (pads < 3'd2) push_byte(burst, triple[15:8]);
            if (pads < 3'd1) push_byte(burst, triple[7:0]);
          end
          clear_group();
        end else begin
          acc = {acc[11:0], v};
          pos = pos + 2'd1;
        end
      end
      if (it.end_of_text) begin
        r.out_byte    = '0;
        r.last_result = 1'b0;
        if (pos != 2'd0) r.result_kind = KIND_BADLEN;
        else if (bad_seen) r.result_kind = KIND_BADCHAR;
        else r.result_kind = KIND_OK;
        burst.push_back(r);
        clear_group();
        bad_seen = 1'b0;
        texts_closed++;
      end
      if (burst.size() > 0) burst[burst.size() - 1].last_result = 1'b1;
      foreach (burst[i]) owed.push_back(burst[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (owed.size() == 0) begin
        $error("result transfer with nothing owed: out_byte %0h result_kind %0d last_result %0d",
               got.out_byte, got.result_kind, got.last_result);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  b64_scoreboard sb = new();

  // Percent chance, per cycle, that each side sits idle. The main sequence
  // changes these between phases of the run.
  int  send_idle_pct;
  int  recv_idle_pct;
  // The main sequence raises hold_req to ask the receiver for one long
  // hold-off; the receiver counts that stretch down itself.
  bit  hold_req;
  int  hold_left;
  // Input transfers sent that carry a character or an end marker.
  int  items_sent;

  base64_stream_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side. Every rising edge it first looks at what the block and the
  // receiver showed just before the edge, so a transfer seen here is exactly
  // the one the block saw, and only then picks the ready level for the next
  // cycle.
  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_item_t mk_item(logic [7:0] c, logic present, logic eot);
    in_item_t it;
    it.in_char      = c;
    it.char_present = present;
    it.end_of_text  = eot;
    return it;
  endfunction

  // Encoder side of the alphabet, used only to build legal text.
  function automatic logic [7:0] b64_char(int unsigned v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic logic [7:0] space_char();
    int unsigned k;
    k = $urandom_range(5);
    return (k == 5) ? 8'h20 : 8'h09 + 8'(k);
  endfunction

  // Offers one item and returns at the edge where it is taken. Valid is left
  // high on return, so a follow-on item without a gap keeps valid up; an idle
  // gap lowers it first. That way valid never gets two updates in one step.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(it);
    if (it.char_present || it.end_of_text) items_sent++;
  endtask

  // Sends text and closes it, either on the last character itself or with a
  // bare end marker whose character byte is random and must be ignored.
  task automatic send_text(logic [7:0] txt[$], bit end_on_char, bit sprinkle_space);
    foreach (txt[i]) begin
      if (sprinkle_space && $urandom_range(9) == 0) send_item(mk_item(space_char(), 1'b1, 1'b0));
      send_item(mk_item(txt[i], 1'b1, end_on_char && (i == txt.size() - 1)));
    end
    if (!end_on_char || txt.size() == 0) send_item(mk_item(8'($urandom_range(255)), 1'b0, 1'b1));
  endtask

  // Legal base64 of zero to four groups, the last group padded with zero, one
  // or two '=' characters.
  task automatic send_legal_text();
    logic [7:0]  txt[$];
    int unsigned groups;
    int unsigned npad;
    groups = $urandom_range(4);
    repeat (groups * 4) txt.push_back(b64_char($urandom_range(63)));
    if (groups > 0) begin
      npad = $urandom_range(2);
      for (int k = 0; k < npad; k++) txt[txt.size() - 1 - k] = PAD_CHAR;
    end
    send_text(txt, $urandom_range(1), 1'b1);
  endtask

  // Broken text: one to nine characters, '=' anywhere, stray bytes of any value.
  task automatic send_broken_text();
    logic [7:0]  txt[$];
    int unsigned len;
    int unsigned pick;
    len = $urandom_range(1, 9);
    repeat (len) begin
      pick = $urandom_range(9);
      if (pick < 5) txt.push_back(b64_char($urandom_range(63)));
      else if (pick < 7) txt.push_back(PAD_CHAR);
      else txt.push_back(8'($urandom_range(255)));
    end
    send_text(txt, $urandom_range(1), 1'b0);
  endtask

  // Single item of any shape: any byte, with or without a character, with or
  // without an end marker.
  task automatic send_noise();
    send_item(mk_item(8'($urandom_range(255)), 1'(($urandom_range(1))),
                      1'($urandom_range(4) == 0)));
  endtask

  // Holds the sender off until every owed result has been seen.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int target);
    int unsigned pick;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) send_legal_text();
      else if (pick < 85) send_broken_text();
      else send_noise();
    end
  endtask

  // Main sequence: reset, a directed pass over the corner cases, then three
  // random phases with different idling on the two sides, a long receiver
  // hold-off in the last one, and a drain between phases.
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    items_sent    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty text closes cleanly.
    send_item(mk_item(8'h00, 1'b0, 1'b1));
    // "TWE=" closed on its last character: two bytes and the status together.
    send_text('{8'h54, 8'h57, 8'h45, PAD_CHAR}, 1'b1, 1'b0);
    // Alphabet extremes: 'A', '/', 'z', '+', then '0', '9' with double padding.
    send_text('{8'h41, 8'h2F, 8'h7A, 8'h2B, 8'h30, 8'h39, PAD_CHAR, PAD_CHAR}, 1'b1, 1'b0);
    // Space, tab and line feed are skipped, and an empty item is ignored.
    send_item(mk_item(8'h20, 1'b1, 1'b0));
    send_item(mk_item(8'h09, 1'b1, 1'b0));
    send_item(mk_item(8'hFF, 1'b0, 1'b0));
    send_item(mk_item(8'h0A, 1'b1, 1'b1));
    // A top-bit byte is invalid: no data bytes, and the bad-character status.
    send_text('{8'hFF, 8'h41, 8'h0D, 8'h41, 8'h41}, 1'b0, 1'b0);
    // An incomplete group that also holds an invalid character reports
    // the bad length.
    send_text('{8'h80, 8'h51}, 1'b1, 1'b0);
    wait_for_drain();

    send_idle_pct = 25;
    recv_idle_pct = 52;
    random_phase(items_sent + 100);
    wait_for_drain();

    send_idle_pct = 52;
    recv_idle_pct = 25;
    random_phase(items_sent + 100);
    wait_for_drain();

    // No idling on either side. The receiver starts with a long hold-off
    // while the sender keeps offering text, so the block fills and stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    random_phase(items_sent + 110);
    wait_for_drain();

    repeat (20) @(posedge clk);
    $display("Covered %0d input transfers and %0d results over %0d closed texts,",
             items_sent, sb.checked, sb.texts_closed);
    $display("including a long result stall and drains between idle phases.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("base64_stream_decoder_unit: match");
    end else begin
      $display("base64_stream_decoder_unit: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("base64_stream_decoder_unit: mismatch");
    $finish;
  end

endmodule
